[rtl/core/decimal_accumulator_machine_core_top_macros.svh]
// Assertion macros used by the checker file of the machine core.
`ifndef DECIMAL_ACCUMULATOR_MACHINE_CORE_TOP_MACROS_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_CORE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DAM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/dam_pkg.sv]
// Package with types and constants of the decimal accumulator machine core.
`default_nettype none
package dam_pkg;
  localparam int MemWordsDefault = 10000;
  localparam int WordMax = 999999;
  localparam int OpDiv = 10000;
  // Reciprocal of 625 scaled by 2**26; with a prior shift by 4 it divides
  // any magnitude below 2**20 by 10000 exactly.
  localparam logic [16:0] SplitRecip = 17'd107375;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0, CMD_EXEC = 2'd1, CMD_RESTART = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BAD_OP = 2'd1, ST_DIV_ZERO = 2'd2, ST_BAD_ADDR = 2'd3
  } status_t;

  localparam logic [6:0] OP_READ = 7'd10, OP_WRITE = 7'd11, OP_LOAD = 7'd20,
    OP_LOADIM = 7'd21, OP_LOADX = 7'd22, OP_LOADIDX = 7'd23, OP_STORE = 7'd25,
    OP_STOREIDX = 7'd26, OP_ADD = 7'd30, OP_ADDX = 7'd31, OP_SUB = 7'd32,
    OP_SUBX = 7'd33, OP_DIV = 7'd34, OP_DIVX = 7'd35, OP_MUL = 7'd36,
    OP_MULX = 7'd37, OP_INC = 7'd38, OP_DEC = 7'd39, OP_BR = 7'd40,
    OP_BRNEG = 7'd41, OP_BRZERO = 7'd42, OP_SWAP = 7'd43, OP_HALT = 7'd45,
    OP_BAD = 7'd127;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FETCH, S_FWAIT, S_SPLIT, S_REM, S_OPRD, S_OWAIT, S_EXEC,
    S_MDIV, S_MDFIX, S_DONE
  } state_t;

  // Saturate a 21-bit signed value to the word range.
  function automatic logic [31:0] clamp21(input logic signed [20:0] v);
    logic [31:0] r;
    if (v > 21'sd999999) r = 32'd999999;
    else if (v < -21'sd999999) r = -32'sd999999;
    else r = {{11{v[20]}}, v};
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/core/dam_muldiv.sv]
// Shared iterative unit: 32-bit shift-add multiply and restoring magnitude divide.
`default_nettype none
module dam_muldiv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      result
);
  logic [5:0]  count;
  logic        busy;
  logic        div_mode;
  logic        neg;
  logic [31:0] acc;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [32:0] rem_sh;
  logic [32:0] trial;

  assign rem_sh = {acc, opa[31]};
  assign trial = rem_sh - {1'b0, opb};

  // One product bit or one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd32;
        div_mode <= is_div;
        acc <= '0;
        if (is_div) begin
          neg <= a[31] ^ b[31];
          opa <= a[31] ? -a : a;
          opb <= b[31] ? -b : b;
        end else begin
          neg <= 1'b0;
          opa <= a;
          opb <= b;
        end
      end else if (busy) begin
        if (div_mode) begin
          if (!trial[32]) acc <= trial[31:0];
          else acc <= rem_sh[31:0];
          opa <= {opa[30:0], ~trial[32]};
        end else begin
          if (opb[0]) acc <= acc + opa;
          opa <= {opa[30:0], 1'b0};
          opb <= {1'b0, opb[31:1]};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = div_mode ? (neg ? -opa : opa) : acc;
endmodule
`default_nettype wire

[rtl/core/decimal_accumulator_machine_core_top.sv]
// Top level of the decimal accumulator machine core.
// Usage: one input channel (command, load_address, data_value) and one result
// channel, both valid/ready. Each accepted transfer gives exactly one result.
// A load, restart, unused command or execute while halted goes from the fetch
// state straight to the done state. An execute passes through fetch, fetch
// wait, opcode split by reciprocal multiplication, remainder, operand read,
// operand wait and execute. A multiply or a divide by a nonzero value then
// waits for the shared unit, which works one bit per cycle, and a fix-up state.
// Throughput is one item at a time: in_ready is low from acceptance until the
// result transfer completes, and after that transfer the block returns to
// idle before it takes the next input.
// After reset the memory is swept to zero, one word per cycle; no item is
// accepted during the sweep.
// The result is held in an output register until the receiver takes it; a
// stalled receiver holds the block in its done state.
`default_nettype none
module decimal_accumulator_machine_core_top #(
  parameter int MEM_WORDS = dam_pkg::MemWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [13:0] load_address,
  input  wire logic signed [20:0] data_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             write_valid,
  output logic signed [31:0] write_value,
  output logic             read_used,
  output logic             is_halted,
  output logic [1:0]       status,
  output logic [13:0]      program_counter,
  output logic signed [31:0] acc_value,
  output logic signed [31:0] index_value
);
  localparam int AW = $clog2(MEM_WORDS);

  dam_pkg::state_t state, state_next;
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rd_data;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [1:0]  cmd;
  logic [13:0] laddr;
  logic [20:0] dval;
  logic [31:0] acc, idx, word;
  logic [13:0] pc;
  logic [13:0] pc_inc;
  logic        halt;
  dam_pkg::status_t st;
  logic [13:0] clr;
  logic [6:0]  op;
  logic [13:0] opd;
  logic        md_start, md_div, md_done;
  logic [31:0] md_a, md_b, md_res;
  logic [31:0] mag;
  logic [32:0] q_prod;

  // Memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  dam_muldiv u_md (
    .clk(clk), .rst(rst), .start(md_start), .is_div(md_div),
    .a(md_a), .b(md_b), .done(md_done), .result(md_res)
  );

  assign mag = word[31] ? -word : word;
  assign pc_inc = pc + 14'd1;

  // Opcode as magnitude / 10000: a shift by 4, then a reciprocal of 625.
  assign q_prod = {17'd0, mag[19:4]} * {16'd0, dam_pkg::SplitRecip};

  function automatic logic uses_opd(input logic [6:0] o);
    return o == dam_pkg::OP_READ || o == dam_pkg::OP_WRITE || o == dam_pkg::OP_LOAD ||
      o == dam_pkg::OP_LOADX || o == dam_pkg::OP_STORE || o == dam_pkg::OP_ADD ||
      o == dam_pkg::OP_SUB || o == dam_pkg::OP_DIV || o == dam_pkg::OP_MUL;
  endfunction
  function automatic logic uses_idx(input logic [6:0] o);
    return o == dam_pkg::OP_LOADIDX || o == dam_pkg::OP_STOREIDX ||
      o == dam_pkg::OP_ADDX || o == dam_pkg::OP_SUBX || o == dam_pkg::OP_DIVX ||
      o == dam_pkg::OP_MULX;
  endfunction

  logic opd_ok, idx_ok;
  assign opd_ok = {18'd0, opd} < 32'(MEM_WORDS);
  assign idx_ok = idx < 32'(MEM_WORDS);

  // Next-state and memory port control.
  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = clr[AW-1:0];
    wdata = '0;
    raddr = pc[AW-1:0];
    md_start = 1'b0;
    md_div = 1'b0;
    md_a = '0;
    md_b = '0;
    unique case (state)
      dam_pkg::S_CLEAR: begin
        we = 1'b1;
        if (32'(clr) == 32'(MEM_WORDS - 1)) state_next = dam_pkg::S_IDLE;
      end
      dam_pkg::S_IDLE: if (in_valid) state_next = dam_pkg::S_FETCH;
      dam_pkg::S_FETCH: begin
        if (cmd == dam_pkg::CMD_LOAD) begin
          we = {18'd0, laddr} < 32'(MEM_WORDS);
          waddr = laddr[AW-1:0];
          wdata = dam_pkg::clamp21(dval);
          state_next = dam_pkg::S_DONE;
        end else if (cmd == dam_pkg::CMD_EXEC && !halt && {18'd0, pc} < 32'(MEM_WORDS))
          state_next = dam_pkg::S_FWAIT;
        else state_next = dam_pkg::S_DONE;
      end
      dam_pkg::S_FWAIT: state_next = dam_pkg::S_SPLIT;
      dam_pkg::S_SPLIT: state_next = dam_pkg::S_REM;
      dam_pkg::S_REM: state_next = dam_pkg::S_OPRD;
      dam_pkg::S_OPRD: begin
        raddr = uses_idx(op) ? idx[AW-1:0] : opd[AW-1:0];
        state_next = dam_pkg::S_OWAIT;
      end
      dam_pkg::S_OWAIT: begin
        raddr = uses_idx(op) ? idx[AW-1:0] : opd[AW-1:0];
        state_next = dam_pkg::S_EXEC;
      end
      dam_pkg::S_EXEC: begin
        state_next = dam_pkg::S_DONE;
        if (!((uses_opd(op) && !opd_ok) || (uses_idx(op) && !idx_ok))) begin
          if (op == dam_pkg::OP_READ) begin
            we = 1'b1; waddr = opd[AW-1:0]; wdata = dam_pkg::clamp21(dval);
          end else if (op == dam_pkg::OP_STORE || op == dam_pkg::OP_STOREIDX) begin
            we = 1'b1;
            waddr = (op == dam_pkg::OP_STORE) ? opd[AW-1:0] : idx[AW-1:0];
            wdata = acc;
          end else if (op == dam_pkg::OP_MUL || op == dam_pkg::OP_MULX ||
                       ((op == dam_pkg::OP_DIV || op == dam_pkg::OP_DIVX) && rd_data != 0)) begin
            md_start = 1'b1;
            md_div = (op == dam_pkg::OP_DIV || op == dam_pkg::OP_DIVX);
            md_a = acc;
            md_b = rd_data;
            state_next = dam_pkg::S_MDIV;
          end
        end
      end
      dam_pkg::S_MDIV: if (md_done) state_next = dam_pkg::S_MDFIX;
      dam_pkg::S_MDFIX: state_next = dam_pkg::S_DONE;
      dam_pkg::S_DONE: if (out_ready) state_next = dam_pkg::S_IDLE;
      default: state_next = dam_pkg::S_IDLE;
    endcase
  end

  assign in_ready = (state == dam_pkg::S_IDLE);

  // Machine registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dam_pkg::S_CLEAR;
      clr <= '0;
      acc <= '0; idx <= '0; pc <= '0; halt <= 1'b0; st <= dam_pkg::ST_OK;
      out_valid <= 1'b0;
      write_valid <= 1'b0; read_used <= 1'b0; write_value <= '0;
    end else begin
      state <= state_next;
      if (state == dam_pkg::S_CLEAR) clr <= clr + 14'd1;
      if (state == dam_pkg::S_IDLE && in_valid) begin
        cmd <= command; laddr <= load_address; dval <= data_value;
        write_valid <= 1'b0; read_used <= 1'b0; write_value <= '0;
      end
      if (state == dam_pkg::S_FETCH) begin
        if (cmd == dam_pkg::CMD_RESTART) begin
          acc <= '0; idx <= '0; pc <= '0; halt <= 1'b0; st <= dam_pkg::ST_OK;
        end else if (cmd == dam_pkg::CMD_EXEC && !halt && {18'd0, pc} >= 32'(MEM_WORDS)) begin
          halt <= 1'b1; st <= dam_pkg::ST_BAD_ADDR;
        end
      end
      if (state == dam_pkg::S_FWAIT) word <= rd_data;
      // Magnitudes above the word range hold an opcode of 100 or more.
      if (state == dam_pkg::S_SPLIT)
        op <= (mag > 32'(dam_pkg::WordMax)) ? dam_pkg::OP_BAD : q_prod[32:26];
      if (state == dam_pkg::S_REM)
        opd <= 14'(mag - {25'd0, op} * 32'(dam_pkg::OpDiv));
      if (state == dam_pkg::S_EXEC) begin
        if ((uses_opd(op) && !opd_ok) || (uses_idx(op) && !idx_ok)) begin
          halt <= 1'b1; st <= dam_pkg::ST_BAD_ADDR;
        end else begin
          unique case (op)
            dam_pkg::OP_READ: begin read_used <= 1'b1; pc <= pc_inc; end
            dam_pkg::OP_WRITE: begin
              write_valid <= 1'b1; write_value <= rd_data; pc <= pc_inc;
            end
            dam_pkg::OP_LOAD, dam_pkg::OP_LOADIDX: begin acc <= rd_data; pc <= pc_inc; end
            dam_pkg::OP_LOADIM: begin acc <= {18'd0, opd}; pc <= pc_inc; end
            dam_pkg::OP_LOADX: begin idx <= rd_data; pc <= pc_inc; end
            dam_pkg::OP_ADD, dam_pkg::OP_ADDX: begin acc <= acc + rd_data; pc <= pc_inc; end
            dam_pkg::OP_SUB, dam_pkg::OP_SUBX: begin acc <= acc - rd_data; pc <= pc_inc; end
            dam_pkg::OP_DIV, dam_pkg::OP_DIVX: begin
              pc <= pc_inc;
              if (rd_data == 0) begin halt <= 1'b1; st <= dam_pkg::ST_DIV_ZERO; end
            end
            dam_pkg::OP_INC: begin idx <= idx + 32'd1; pc <= pc_inc; end
            dam_pkg::OP_DEC: begin idx <= idx - 32'd1; pc <= pc_inc; end
            dam_pkg::OP_BR: pc <= opd;
            dam_pkg::OP_BRNEG: pc <= acc[31] ? opd : pc_inc;
            dam_pkg::OP_BRZERO: pc <= (acc == 0) ? opd : pc_inc;
            dam_pkg::OP_SWAP: begin acc <= idx; idx <= acc; pc <= pc_inc; end
            dam_pkg::OP_HALT: begin halt <= 1'b1; st <= dam_pkg::ST_OK; end
            dam_pkg::OP_STORE, dam_pkg::OP_STOREIDX, dam_pkg::OP_MUL,
            dam_pkg::OP_MULX: pc <= pc_inc;
            default: begin halt <= 1'b1; st <= dam_pkg::ST_BAD_OP; end
          endcase
        end
      end
      if (state == dam_pkg::S_MDIV && md_done) acc <= md_res;
      if (state_next == dam_pkg::S_DONE && state != dam_pkg::S_DONE) out_valid <= 1'b1;
      if (state == dam_pkg::S_DONE && out_ready) out_valid <= 1'b0;
    end
  end

  assign is_halted = halt;
  assign status = st;
  assign program_counter = pc;
  assign acc_value = acc;
  assign index_value = idx;
endmodule
`default_nettype wire

[rtl/core/dam_checker.sv]
// Port-level checker for the machine core, bound to the top level.
`default_nettype none
`include "decimal_accumulator_machine_core_top_macros.svh"
module dam_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic is_halted,
  input wire logic [1:0] status,
  input wire logic write_valid,
  input wire logic read_used
);
  `DAM_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready, "ready while result pending")
  `DAM_ASSERT_NEXT(a_one_result, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `DAM_ASSERT_IMP(a_status_halt, clk, rst, status != 2'd0, is_halted, "status set but running")
  `DAM_ASSERT_IMP(a_excl, clk, rst, out_valid, !(write_valid && read_used), "write and read both")
endmodule
bind decimal_accumulator_machine_core_top dam_checker u_dam_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .is_halted(is_halted),
  .status(status), .write_valid(write_valid), .read_used(read_used)
);
`default_nettype wire

[tb/decimal_accumulator_machine_core_top_test.sv]
// Self-checking testbench of the decimal accumulator machine core.
`timescale 1ns / 1ps
`default_nettype none
module decimal_accumulator_machine_core_top_test;

  localparam int Words = 10000;
  localparam int CycleLimit = 2000000;

  // One result of the machine as seen on the output channel.
  typedef struct {
    logic        wv;
    logic [31:0] wval;
    logic        ru;
    logic        halted;
    logic [1:0]  st;
    logic [13:0] pc;
    logic [31:0] acc;
    logic [31:0] idx;
  } step_result_t;

  // Machine model plus the queue of predicted step results.
  class machine_scoreboard;
    logic [31:0] mem [Words];
    logic [31:0] acc, idx;
    logic [13:0] pc;
    logic        halted;
    logic [1:0]  st;
    step_result_t pending[$];
    int errors;
    int steps_done;

    function new();
      foreach (mem[i]) mem[i] = '0;
      acc = '0; idx = '0; pc = '0; halted = 1'b0; st = dam_pkg::ST_OK; errors = 0;
      steps_done = 0;
    endfunction

    function logic [31:0] sat(logic signed [20:0] v);
      logic [31:0] r;
      if (v > 21'sd999999) r = 32'd999999;
      else if (v < -21'sd999999) r = -32'sd999999;
      else r = {{11{v[20]}}, v};
      return r;
    endfunction

    function logic [31:0] quot(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void halt_with(logic [1:0] code);
      halted = 1'b1;
      st = code;
    endfunction

    // Predict the result of one accepted command.
    function void note_input(logic [1:0] cmd, logic [13:0] addr, logic signed [20:0] dv);
      step_result_t r;
      logic [31:0] w, mag, op, opd, m;
      logic uses_opd, uses_idx;
      logic [13:0] nxt;
      r.wv = 1'b0; r.wval = '0; r.ru = 1'b0;
      if (cmd == dam_pkg::CMD_LOAD) begin
        if (addr < Words) mem[addr] = sat(dv);
      end else if (cmd == dam_pkg::CMD_RESTART) begin
        acc = '0; idx = '0; pc = '0; halted = 1'b0; st = dam_pkg::ST_OK;
      end else if (cmd == dam_pkg::CMD_EXEC && !halted) begin
        if (pc >= Words) begin
          halt_with(dam_pkg::ST_BAD_ADDR);
        end else begin
          w = mem[pc];
          mag = w[31] ? -w : w;
          op = mag / 10000;
          opd = mag % 10000;
          uses_opd = op inside {dam_pkg::OP_READ, dam_pkg::OP_WRITE, dam_pkg::OP_LOAD,
                                dam_pkg::OP_LOADX, dam_pkg::OP_STORE, dam_pkg::OP_ADD,
                                dam_pkg::OP_SUB, dam_pkg::OP_DIV, dam_pkg::OP_MUL};
          uses_idx = op inside {dam_pkg::OP_LOADIDX, dam_pkg::OP_STOREIDX,
                                dam_pkg::OP_ADDX, dam_pkg::OP_SUBX, dam_pkg::OP_DIVX,
                                dam_pkg::OP_MULX};
          nxt = pc + 14'd1;
          if ((uses_opd && opd >= Words) || (uses_idx && idx >= Words)) begin
            halt_with(dam_pkg::ST_BAD_ADDR);
          end else begin
            m = uses_opd ? mem[opd] : (uses_idx ? mem[idx] : '0);
            case (op)
              dam_pkg::OP_READ: begin mem[opd] = sat(dv); r.ru = 1'b1; pc = nxt; end
              dam_pkg::OP_WRITE: begin r.wv = 1'b1; r.wval = m; pc = nxt; end
              dam_pkg::OP_LOAD, dam_pkg::OP_LOADIDX: begin acc = m; pc = nxt; end
              dam_pkg::OP_LOADIM: begin acc = opd; pc = nxt; end
              dam_pkg::OP_LOADX: begin idx = m; pc = nxt; end
              dam_pkg::OP_STORE: begin mem[opd] = acc; pc = nxt; end
              dam_pkg::OP_STOREIDX: begin mem[idx] = acc; pc = nxt; end
              dam_pkg::OP_ADD, dam_pkg::OP_ADDX: begin acc = acc + m; pc = nxt; end
              dam_pkg::OP_SUB, dam_pkg::OP_SUBX: begin acc = acc - m; pc = nxt; end
              dam_pkg::OP_DIV, dam_pkg::OP_DIVX: begin
                if (m != 0) acc = quot(acc, m);
                else halt_with(dam_pkg::ST_DIV_ZERO);
                pc = nxt;
              end
              dam_pkg::OP_MUL, dam_pkg::OP_MULX: begin acc = acc * m; pc = nxt; end
              dam_pkg::OP_INC: begin idx = idx + 1; pc = nxt; end
              dam_pkg::OP_DEC: begin idx = idx - 1; pc = nxt; end
              dam_pkg::OP_BR: pc = opd[13:0];
              dam_pkg::OP_BRNEG: pc = acc[31] ? opd[13:0] : nxt;
              dam_pkg::OP_BRZERO: pc = (acc == 0) ? opd[13:0] : nxt;
              dam_pkg::OP_SWAP: begin m = acc; acc = idx; idx = m; pc = nxt; end
              dam_pkg::OP_HALT: halt_with(dam_pkg::ST_OK);
              default: halt_with(dam_pkg::ST_BAD_OP);
            endcase
          end
        end
      end
      r.halted = halted; r.st = st; r.pc = pc; r.acc = acc; r.idx = idx;
      pending.push_back(r);
    endfunction

    function void field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(step_result_t a);
      step_result_t e;
      steps_done++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none actual pc %0h", $time, a.pc);
        errors++;
        return;
      end
      e = pending.pop_front();
      field("write_valid", e.wv, a.wv);
      field("write_value", e.wval, a.wval);
      field("read_used", e.ru, a.ru);
      field("is_halted", e.halted, a.halted);
      field("status", e.st, a.st);
      field("program_counter", e.pc, a.pc);
      field("acc_value", e.acc, a.acc);
      field("index_value", e.idx, a.idx);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = dam_pkg::CMD_LOAD;
  logic [13:0] load_address = '0;
  logic signed [20:0] data_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic write_valid, read_used, is_halted;
  logic signed [31:0] write_value, acc_value, index_value;
  logic [1:0] status;
  logic [13:0] program_counter;

  machine_scoreboard sb = new();
  int cycles = 0;
  bit stim_done = 1'b0;

  always #5 clk = ~clk;

  decimal_accumulator_machine_core_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .load_address(load_address), .data_value(data_value),
    .out_valid(out_valid), .out_ready(out_ready), .write_valid(write_valid),
    .write_value(write_value), .read_used(read_used), .is_halted(is_halted),
    .status(status), .program_counter(program_counter), .acc_value(acc_value),
    .index_value(index_value)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Note each accepted input transfer.
  always @(posedge clk)
    if (!rst && in_valid && in_ready) sb.note_input(command, load_address, data_value);

  // Check each result transfer.
  always @(posedge clk) begin
    step_result_t a;
    if (!rst && out_valid && out_ready) begin
      a.wv = write_valid; a.wval = write_value; a.ru = read_used; a.halted = is_halted;
      a.st = status; a.pc = program_counter; a.acc = acc_value; a.idx = index_value;
      sb.check_result(a);
    end
  end

  // Receiver: random stalls, with stall-free stretches.
  initial begin
    int gap;
    int calm;
    calm = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (calm > 0) ? 0 : $urandom_range(0, 16);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 30) == 0) calm = 40;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Send one command and wait for its transfer; valid stays up when no gap follows.
  task automatic send(logic [1:0] cmd, logic [13:0] addr, logic signed [20:0] dv,
                      int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    load_address <= addr;
    data_value <= dv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [20:0] instr(int op, int opd, bit neg);
    int v;
    v = op * 10000 + opd;
    if (v > 999999) v = 999999;
    return 21'(neg ? -v : v);
  endfunction

  // Random gap, zero during quiet stretches.
  function automatic int pick_gap(int quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  int op_list[23] = '{10, 11, 20, 21, 22, 23, 25, 26, 30, 31, 32, 33, 34, 35, 36, 37,
                      38, 39, 40, 41, 42, 43, 45};

  initial begin
    int n, k, len, op, opd, quiet;
    logic [13:0] base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes of loads, an unused command, branches, a bad opcode, execution while halted and restarts.
    send(dam_pkg::CMD_LOAD, 14'd0, 21'sd999999, 0);
    send(dam_pkg::CMD_LOAD, 14'd9999, -21'sd1048576, 0);
    send(dam_pkg::CMD_LOAD, 14'd16383, 21'sd1048575, 0);
    send(dam_pkg::CMD_NONE, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_LOAD, 14'd1, instr(21, 0, 0), 1);
    send(dam_pkg::CMD_LOAD, 14'd2, instr(34, 50, 0), 0);
    send(dam_pkg::CMD_LOAD, 14'd3, instr(40, 9999, 0), 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 2);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_LOAD, 14'd4, instr(10, 9999, 1), 0);
    send(dam_pkg::CMD_RESTART, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_LOAD, 14'd0, instr(40, 9999, 0), 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_RESTART, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_LOAD, 14'd0, instr(99, 0, 0), 0);
    send(dam_pkg::CMD_EXEC, 14'd0, 21'sd0, 0);
    send(dam_pkg::CMD_RESTART, 14'd0, 21'sd0, 3);

    // Random part: short programs with random content, then execution bursts.
    n = 0;
    quiet = 0;
    while (n < 500) begin
      quiet = ($urandom_range(0, 5) == 0);
      base = 14'($urandom_range(0, 40));
      len = $urandom_range(3, 12);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) op = $urandom_range(0, 99);
        else op = op_list[$urandom_range(0, 22)];
        case ($urandom_range(0, 9))
          0: opd = $urandom_range(0, 9999);
          1: opd = 9999;
          default: opd = $urandom_range(0, 60);
        endcase
        send(dam_pkg::CMD_LOAD, 14'(base + k), instr(op, opd, $urandom_range(0, 7) == 0),
             pick_gap(quiet));
        n++;
      end
      // Data words with full-range or small values.
      for (k = 0; k < 4; k++) begin
        send(dam_pkg::CMD_LOAD, 14'($urandom_range(0, 60)),
             21'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20)),
             pick_gap(quiet));
        n++;
      end
      if ($urandom_range(0, 15) == 0) begin
        send(dam_pkg::CMD_LOAD, 14'($urandom_range(10000, 16383)), 21'($urandom),
             pick_gap(quiet));
        n++;
      end
      send(dam_pkg::CMD_RESTART, 14'd0, 21'sd0, pick_gap(quiet));
      n++;
      // Jump to the start of the program with a branch at address 0 when needed.
      if (base != 0) begin
        send(dam_pkg::CMD_LOAD, 14'd0, instr(40, int'(base), 0), pick_gap(quiet));
        n++;
      end
      for (k = 0; k < len + 6; k++) begin
        send(($urandom_range(0, 30) == 0) ? dam_pkg::CMD_NONE : dam_pkg::CMD_EXEC,
             14'($urandom), 21'($urandom), pick_gap(quiet));
        n++;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    // Drain: wait for every predicted result, then a short settle.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d step results from %0d-item random programs and directed cases.",
             sb.steps_done, n);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/dam_pkg.sv
rtl/core/dam_muldiv.sv
rtl/core/decimal_accumulator_machine_core_top.sv
rtl/core/dam_checker.sv
tb/decimal_accumulator_machine_core_top_test.sv
